@@ hw/rtl/mvs_pkg.sv @@
// Shared types, constants and helpers for the multiversion store.
`default_nettype none

package mvs_pkg;

   // Store geometry
   localparam int NUM_KEYS     = 1024;
   localparam int VERSIONS     = 8;
   localparam int KEY_W        = 10;
   localparam int SLOT_W       = $clog2(VERSIONS);
   localparam int CNT_W        = $clog2(VERSIONS + 1);
   localparam int ADDR_W       = KEY_W + SLOT_W;
   localparam int STAMP_W      = 31;
   localparam int DATA_W       = 32;
   localparam int ACTION_W     = 2;
   localparam int VER_W        = STAMP_W + DATA_W;
   localparam int SLOTS        = NUM_KEYS * VERSIONS;

   // Request queue between front and engine
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Action codes on the request port
   localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CHECK = 2'd2;

   // Request class after decode
   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_READ  = 2'd1,
      KIND_WRITE = 2'd2,
      KIND_CHECK = 2'd3
   } kind_type;

   // Decoded request handed to the engine
   typedef struct packed {
      kind_type            kind;
      logic [KEY_W-1:0]    key;
      logic [STAMP_W-1:0]  stamp;
      logic [DATA_W-1:0]   value;
   } cmd_type;

   // Engine status seen by the front
   typedef struct packed {
      logic clearing;
   } eng_status_type;

   // Version memory address of one slot of one key
   function automatic logic [ADDR_W-1:0] ver_addr(input logic [KEY_W-1:0] key,
                                                  input logic [CNT_W-1:0] slot);
      ver_addr = {key, slot[SLOT_W-1:0]};
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mvs_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mvs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one entry, read one entry
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hw/rtl/mvs_front.sv @@
// Request front end: accept, decode and queue requests for the engine.
`default_nettype none

module mvs_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic [mvs_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [mvs_pkg::KEY_W-1:0]      req_key,
   input  wire logic [mvs_pkg::STAMP_W-1:0]    req_stamp,
   input  wire logic [mvs_pkg::DATA_W-1:0]     req_write_value,
   input  wire mvs_pkg::eng_status_type        status,
   output logic                                cmd_valid,
   output mvs_pkg::cmd_type                    cmd,
   input  wire logic                           cmd_pop
);

   mvs_pkg::cmd_type                  q_ff [mvs_pkg::QUEUE_DEPTH];
   logic [mvs_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [mvs_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [mvs_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                              push;
   logic                              pop;
   mvs_pkg::cmd_type                  dec;

   // Decode action and range check the key
   always_comb begin
      dec.key   = req_key;
      dec.stamp = req_stamp;
      dec.value = req_write_value;
      unique case (req_action)
         mvs_pkg::ACT_READ:  dec.kind = mvs_pkg::KIND_READ;
         mvs_pkg::ACT_WRITE: dec.kind = mvs_pkg::KIND_WRITE;
         mvs_pkg::ACT_CHECK: dec.kind = mvs_pkg::KIND_CHECK;
         default:            dec.kind = mvs_pkg::KIND_NONE;
      endcase
      if ({1'b0, req_key} >= (mvs_pkg::KEY_W + 1)'(mvs_pkg::NUM_KEYS)) begin
         dec.kind = mvs_pkg::KIND_NONE;
      end
   end

   assign busy      = (cnt_ff == mvs_pkg::QCNT_W'(mvs_pkg::QUEUE_DEPTH)) || status.clearing;
   assign push      = start && !busy;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd       = q_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == mvs_pkg::QPTR_W'(mvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == mvs_pkg::QPTR_W'(mvs_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/mvs_engine.sv @@
// Back-end engine: version scan, ordered insert and the reset clearing pass.
`default_nettype none

module mvs_engine (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        cmd_valid,
   input  wire mvs_pkg::cmd_type            cmd,
   output logic                             cmd_pop,
   output mvs_pkg::eng_status_type          status,
   output logic                             rsp_valid,
   output logic                             rsp_ok,
   output logic [mvs_pkg::DATA_W-1:0]       rsp_read_value,
   output logic                             rsp_overflow
);

   localparam int CNT_W = mvs_pkg::CNT_W;

   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,
      S_IDLE  = 6'b000010,
      S_COUNT = 6'b000100,
      S_SCAN  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_INS   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   mvs_pkg::cmd_type                cmd_ff, cmd_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [CNT_W-1:0]                scan_ff, scan_in;
   logic [CNT_W-1:0]                pidx_ff, pidx_in;
   logic                            pend_ff, pend_in;
   logic [CNT_W-1:0]                pos_ff, pos_in;
   logic [CNT_W-1:0]                sh_ff, sh_in;
   logic [CNT_W-1:0]                wdst_ff, wdst_in;
   logic                            wr_pend_ff, wr_pend_in;
   logic [mvs_pkg::KEY_W-1:0]       clr_ff, clr_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_ok_ff, rsp_ok_in;
   logic [mvs_pkg::DATA_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                            rsp_ovf_ff, rsp_ovf_in;

   logic                            ver_we;
   logic [mvs_pkg::ADDR_W-1:0]      ver_waddr, ver_raddr;
   logic [mvs_pkg::VER_W-1:0]       ver_wdata, ver_rdata;
   logic                            cnt_we;
   logic [mvs_pkg::KEY_W-1:0]       cnt_waddr;
   logic [CNT_W-1:0]                cnt_wdata, cnt_rdata;

   logic                            hit, is_last, issue, full, scan_end;
   logic [CNT_W-1:0]                pos, last;

   mvs_ram #(.WIDTH(mvs_pkg::VER_W), .DEPTH(mvs_pkg::SLOTS)) u_ver_ram (
      .clock    (clock),
      .we       (ver_we),
      .waddr    (ver_waddr),
      .wdata    (ver_wdata),
      .raddr    (ver_raddr),
      .rdata_ff (ver_rdata)
   );

   mvs_ram #(.WIDTH(CNT_W), .DEPTH(mvs_pkg::NUM_KEYS)) u_cnt_ram (
      .clock    (clock),
      .we       (cnt_we),
      .waddr    (cnt_waddr),
      .wdata    (cnt_wdata),
      .raddr    (cmd.key),
      .rdata_ff (cnt_rdata)
   );

   // Scan helpers
   assign hit      = (ver_rdata[mvs_pkg::DATA_W +: mvs_pkg::STAMP_W] <= cmd_ff.stamp);
   assign is_last  = (pidx_ff == cnt_ff - CNT_W'(1));
   assign issue    = (scan_ff < cnt_ff);
   assign full     = (cnt_ff == CNT_W'(mvs_pkg::VERSIONS));
   assign pos      = (pend_ff && hit) ? pidx_ff : cnt_ff;
   assign last     = full ? CNT_W'(mvs_pkg::VERSIONS - 1) : cnt_ff;
   assign scan_end = pend_ff ? (hit || is_last || (cmd_ff.kind == mvs_pkg::KIND_CHECK))
                             : !issue;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      pidx_in      = pidx_ff;
      pend_in      = 1'b0;
      pos_in       = pos_ff;
      sh_in        = sh_ff;
      wdst_in      = wdst_ff;
      wr_pend_in   = 1'b0;
      clr_in       = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_value_in = '0;
      rsp_ovf_in   = 1'b0;
      cmd_pop      = 1'b0;
      ver_we       = 1'b0;
      ver_waddr    = mvs_pkg::ver_addr(cmd_ff.key, pos_ff);
      ver_wdata    = {cmd_ff.stamp, cmd_ff.value};
      ver_raddr    = mvs_pkg::ver_addr(cmd_ff.key, scan_ff);
      cnt_we       = 1'b0;
      cnt_waddr    = cmd_ff.key;
      cnt_wdata    = cnt_ff + CNT_W'(1);

      unique case (state_ff)
         // Seed every key with one zero version
         S_CLEAR: begin
            ver_we    = 1'b1;
            ver_waddr = mvs_pkg::ver_addr(clr_ff, '0);
            ver_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = clr_ff;
            cnt_wdata = CNT_W'(1);
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == mvs_pkg::KEY_W'(mvs_pkg::NUM_KEYS - 1)) begin
               state_in = S_IDLE;
            end
         end
         // Take the next request; drop invalid ones at once
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in  = cmd;
               if (cmd.kind == mvs_pkg::KIND_NONE) begin
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = S_COUNT;
               end
            end
         end
         // Latch the version count of the key
         S_COUNT: begin
            cnt_in   = cnt_rdata;
            scan_in  = '0;
            state_in = S_SCAN;
         end
         // Walk versions newest first, one compare per cycle
         S_SCAN: begin
            if (issue) begin
               pend_in = 1'b1;
               pidx_in = scan_ff;
               scan_in = scan_ff + CNT_W'(1);
            end
            if (scan_end) begin
               pend_in = 1'b0;
               unique case (cmd_ff.kind)
                  mvs_pkg::KIND_READ: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = pend_ff && hit;
                     rsp_value_in = (pend_ff && hit) ? ver_rdata[mvs_pkg::DATA_W-1:0] : '0;
                     state_in     = S_IDLE;
                  end
                  mvs_pkg::KIND_CHECK: begin
                     rsp_valid_in = 1'b1;
                     rsp_ok_in    = pend_ff && hit;
                     state_in     = S_IDLE;
                  end
                  default: begin
                     if (pos >= CNT_W'(mvs_pkg::VERSIONS)) begin
                        // New version would be the oldest of a full key: lose it
                        rsp_valid_in = 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_ovf_in   = 1'b1;
                        state_in     = S_IDLE;
                     end else begin
                        pos_in   = pos;
                        sh_in    = last;
                        state_in = S_SHIFT;
                     end
                  end
               endcase
            end
         end
         // Move older versions down one slot, one per cycle
         S_SHIFT: begin
            ver_raddr = mvs_pkg::ver_addr(cmd_ff.key, sh_ff - CNT_W'(1));
            if (wr_pend_ff) begin
               ver_we    = 1'b1;
               ver_waddr = mvs_pkg::ver_addr(cmd_ff.key, wdst_ff);
               ver_wdata = ver_rdata;
            end
            if (sh_ff > pos_ff) begin
               wr_pend_in = 1'b1;
               wdst_in    = sh_ff;
               sh_in      = sh_ff - CNT_W'(1);
            end else if (!wr_pend_ff) begin
               state_in = S_INS;
            end
         end
         // Store the new version and bump the count unless the key is full
         S_INS: begin
            ver_we       = 1'b1;
            cnt_we       = !full;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_ovf_in   = full;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      cnt_ff       <= cnt_in;
      scan_ff      <= scan_in;
      pidx_ff      <= pidx_in;
      pos_ff       <= pos_in;
      sh_ff        <= sh_in;
      wdst_ff      <= wdst_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_value_ff <= rsp_value_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign status.clearing = (state_ff == S_CLEAR);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_overflow    = rsp_ovf_ff;

   // Version memory is never written while waiting for a request
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !ver_we)
      else $error("version write while idle");

   // Shift pointer never passes the insert slot
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHIFT |-> sh_ff >= pos_ff)
      else $error("shift pointer below insert slot");

   // Count memory changes only during clearing or insert
   a_cnt_write: assert property (@(posedge clock) disable iff (reset)
      cnt_we |-> (state_ff == S_CLEAR || state_ff == S_INS))
      else $error("unexpected count write");

   // No response follows a clearing cycle
   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |=> !rsp_valid)
      else $error("response during clearing pass");

endmodule

`default_nettype wire

@@ hw/rtl/mvcc_version_store.sv @@
// Top level of the multiversion timestamp-ordered version store.
`default_nettype none

// After reset the store runs a clearing pass (one key per cycle) with busy high.
// A request is taken when start is high and busy is low; up to two requests
// queue ahead of the engine. Each request gives exactly one response, shown for
// one cycle with rsp_valid; responses cannot be held off. The engine serves one
// request at a time: unused actions are answered from idle, a read scans the
// versions of its key, a check looks at the newest one, and a write scans, moves
// older versions down and stores the new one. A write that a full key would drop
// at once ends with the scan. The single read port of the version memory serves
// both the scan and the shift.
module mvcc_version_store (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [mvs_pkg::ACTION_W-1:0]  req_action,
   input  wire logic [mvs_pkg::KEY_W-1:0]     req_key,
   input  wire logic [mvs_pkg::STAMP_W-1:0]   req_stamp,
   input  wire logic [mvs_pkg::DATA_W-1:0]    req_write_value,
   output logic                               rsp_valid,
   output logic                               rsp_ok,
   output logic [mvs_pkg::DATA_W-1:0]         rsp_read_value,
   output logic                               rsp_overflow
);

   mvs_pkg::cmd_type         cmd;
   mvs_pkg::eng_status_type  status;
   logic                     cmd_valid;
   logic                     cmd_pop;

   mvs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_key         (req_key),
      .req_stamp       (req_stamp),
      .req_write_value (req_write_value),
      .status          (status),
      .cmd_valid       (cmd_valid),
      .cmd             (cmd),
      .cmd_pop         (cmd_pop)
   );

   mvs_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ok         (rsp_ok),
      .rsp_read_value (rsp_read_value),
      .rsp_overflow   (rsp_overflow)
   );

endmodule

`default_nettype wire
